@@ hdl/itrd_pkg.sv @@
// ----------------------------------------------------------------------------
// itrd_pkg: shared definitions for the radix digit converter
// Types, register indexes, character codes and helper functions used by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package itrd_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int IN_W           = 64;
    localparam int BASE_W         = 6;
    localparam int CHAR_W         = 7;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_CASE = 1'b1;

    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0] ASC_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] ASC_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] ASC_UPPER_A = 7'h41;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PUSH,
        S_RD,
        S_LOAD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic load_err;
        logic div_step;
        logic push;
        logic rd;
        logic out_load;
        logic out_clear;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_top;
        logic quot_zero;
        logic out_done;
        logic out_last;
    } t_stat;

    // Bases outside 2..36 are clamped to the nearest end.
    function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end else begin
            r = b;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [BASE_W-1:0] d,
                                                      input logic up);
        logic [CHAR_W-1:0] r;
        if (d < 6'd10) begin
            r = ASC_ZERO + {1'b0, d};
        end else begin
            r = (up ? ASC_UPPER_A : ASC_LOWER_A) + {1'b0, d} - 7'd10;
        end
        return r;
    endfunction

endpackage

@@ hdl/itrd_if.sv @@
// ----------------------------------------------------------------------------
// itrd_if: channel interfaces of the radix digit converter
// Input value channel, digit output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface itrd_in_if;
    logic                       valid;
    logic                       ready;
    logic [itrd_pkg::IN_W-1:0]  value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itrd_out_if;
    logic                         valid;
    logic                         ready;
    logic [itrd_pkg::CHAR_W-1:0]  digit_char;
    logic                         is_last;
    logic                         range_error;
    modport source (output valid, output digit_char, output is_last,
                    output range_error, input ready);
    modport sink   (input valid, input digit_char, input is_last,
                    input range_error, output ready);
endinterface

interface itrd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [itrd_pkg::CFG_IDX_W-1:0]  index;
    logic [itrd_pkg::BASE_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/integer_to_radix_digits_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top: unsigned integer to ASCII digit string
// Converts one value per transaction into its digits in a base from 2 to 36.
// ----------------------------------------------------------------------------
// Channels: i_in_ch carries one value per transaction. o_out_ch returns one
// ASCII digit per transaction, most significant first, with is_last set on
// the final digit. A value with its top bit set returns a single transaction
// with range_error and is_last set and a zero character. i_cfg_ch writes the
// base (index 0) and the letter case (index 1); it is always ready and
// should only be used while no conversion is in flight.
// Operation: each digit costs one bit-serial division over all VALUE_BITS
// bits on the shared divider plus one push onto the digit stack; once the
// quotient is zero the digits are popped and presented one at a time, each
// after the previous one has been taken. One value is converted at a time;
// the input is ready again once the last digit has been taken.
// Reset returns the base to 10 and lower case and drops any pending work.
// A stalled receiver simply holds the current digit in the output register.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_top
    import itrd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itrd_in_if.sink     i_in_ch,
    itrd_out_if.source  o_out_ch,
    itrd_cfg_if.sink    i_cfg_ch
);

    t_cmd  cmd;
    t_stat stat;

    itrd_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    itrd_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (i_in_ch),
        .o_out_ch (o_out_ch),
        .i_cfg_ch (i_cfg_ch),
        .i_cmd    (cmd),
        .o_stat   (stat)
    );

endmodule

@@ hdl/itrd_ram.sv @@
// ----------------------------------------------------------------------------
// itrd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module itrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/itrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// itrd_ctrl: sequencer of the radix digit converter
// Runs one bit-serial division per digit, then pops the digit stack.
// ----------------------------------------------------------------------------
module itrd_ctrl
    import itrd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam int CW = $clog2(VALUE_BITS);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_bit, n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                n_bit          = '0;
                if (i_stat.in_valid) begin
                    if (i_stat.in_top) begin
                        o_cmd.load_err = 1'b1;
                        n_state        = S_OUT;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_bit          = r_bit + CW'(1);
                if (r_bit == CW'(VALUE_BITS - 1)) begin
                    n_bit   = '0;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = i_stat.quot_zero ? S_RD : S_DIV;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_done) begin
                    o_cmd.out_clear = 1'b1;
                    n_state         = i_stat.out_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/itrd_dpath.sv @@
// ----------------------------------------------------------------------------
// itrd_dpath: datapath of the radix digit converter
// Configuration registers, restoring divider, digit stack and output register.
// ----------------------------------------------------------------------------
module itrd_dpath
    import itrd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    itrd_in_if.sink      i_in_ch,
    itrd_out_if.source   o_out_ch,
    itrd_cfg_if.sink     i_cfg_ch,
    input  t_cmd         i_cmd,
    output t_stat        o_stat
);

    localparam int CW = $clog2(VALUE_BITS);

    logic [BASE_W-1:0]     r_out_base;
    logic                  r_upper;
    logic [VALUE_BITS-1:0] r_val;
    logic [BASE_W-1:0]     r_rem;
    logic [CW-1:0]         r_cnt;
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    logic                  r_out_last;
    logic                  r_out_err;

    logic [BASE_W-1:0]     base;
    logic [BASE_W:0]       trial;
    logic [BASE_W:0]       diff;
    logic                  ge;
    logic [CW-1:0]         rd_addr;
    logic [BASE_W-1:0]     rd_digit;

    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_base <= BASE_RESET;
            r_upper    <= 1'b0;
        end else if (i_cfg_ch.valid) begin
            unique case (i_cfg_ch.index)
                REG_OUT_BASE:   r_out_base <= i_cfg_ch.data;
                REG_UPPER_CASE: r_upper    <= i_cfg_ch.data[0];
                default:        r_upper    <= r_upper;
            endcase
        end
    end

    // One quotient bit per cycle: shift the next dividend bit into the
    // remainder and subtract the base when it fits.
    assign base  = eff_base(r_out_base);
    assign trial = {r_rem, r_val[VALUE_BITS-1]};
    assign ge    = trial >= {1'b0, base};
    assign diff  = trial - {1'b0, base};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= i_in_ch.value[VALUE_BITS-1:0];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_val <= {r_val[VALUE_BITS-2:0], ge};
            r_rem <= ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
        end else if (i_cmd.push) begin
            r_rem <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.push) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (i_cmd.rd) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign rd_addr = r_cnt - CW'(1);

    itrd_ram #(
        .WIDTH (BASE_W),
        .DEPTH (VALUE_BITS)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (r_cnt),
        .i_wr_data (r_rem),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_digit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load || i_cmd.load_err) begin
            r_out_valid <= 1'b1;
        end else if (i_cmd.out_clear) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_out_char <= '0;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end else if (i_cmd.out_load) begin
            r_out_char <= digit_ascii(rd_digit, r_upper);
            r_out_last <= (r_cnt == '0);
            r_out_err  <= 1'b0;
        end
    end

    assign i_in_ch.ready        = i_cmd.in_ready;
    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.digit_char  = r_out_char;
    assign o_out_ch.is_last     = r_out_last;
    assign o_out_ch.range_error = r_out_err;

    assign o_stat.in_valid  = i_in_ch.valid;
    assign o_stat.in_top    = i_in_ch.value[VALUE_BITS-1];
    assign o_stat.quot_zero = (r_val == '0);
    assign o_stat.out_done  = r_out_valid && o_out_ch.ready;
    assign o_stat.out_last  = r_out_last;

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the radix digit converter
// Drives values through the input channel under several base and letter-case
// settings and checks every returned digit transaction against a digit
// string computed by repeated division inside the scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import itrd_pkg::*;

    localparam int          VALUE_BITS   = VALUE_BITS_DEF;
    localparam int unsigned LIMIT_CYCLES = 3_000_000;
    localparam int          LONG_HOLD    = 500;
    localparam int          DRAIN_CYCLES = 20;

    typedef logic [IN_W-1:0] t_value;

    class digit_scoreboard;
        typedef struct packed {
            logic [CHAR_W-1:0] code;
            logic              last;
            logic              err;
        } t_digit;

        logic [BASE_W-1:0] radix_reg;
        logic              upper_reg;
        t_digit            expected_digits[$];
        int                errors;

        function new();
            radix_reg = BASE_RESET;
            upper_reg = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BASE_W-1:0] data);
            if (idx == REG_OUT_BASE) begin
                radix_reg = data;
            end else begin
                upper_reg = data[0];
            end
        endfunction

        // Expands one accepted value into its digit string, most significant first.
        function void predict_digits(t_value raw);
            string  digit_set;
            t_value v;
            t_value rem;
            t_value radix;
            byte    c;
            t_digit d;
            t_digit run[$];
            int     n;
            digit_set = "0123456789abcdefghijklmnopqrstuvwxyz";
            v = raw & ((~t_value'(0)) >> (IN_W - VALUE_BITS));
            if (radix_reg < BASE_MIN) begin
                radix = t_value'(BASE_MIN);
            end else if (radix_reg > BASE_MAX) begin
                radix = t_value'(BASE_MAX);
            end else begin
                radix = t_value'(radix_reg);
            end
            if (v[VALUE_BITS-1]) begin
                d.code = '0;
                d.last = 1'b1;
                d.err  = 1'b1;
                expected_digits.push_back(d);
                return;
            end
            n = 0;
            do begin
                rem = v % radix;
                c = digit_set[rem];
                if (upper_reg && c >= "a") begin
                    c = c - 8'd32;
                end
                d.code = c[CHAR_W-1:0];
                d.last = 1'b0;
                d.err  = 1'b0;
                run.push_front(d);
                v = v / radix;
                n++;
            end while (v != 0 && n < 64);
            run[run.size()-1].last = 1'b1;
            foreach (run[k]) begin
                expected_digits.push_back(run[k]);
            end
        endfunction

        function void check_digit(logic [CHAR_W-1:0] code, logic last, logic err);
            t_digit want;
            if (expected_digits.size() == 0) begin
                $error("unexpected digit transaction: digit_char %0d is_last %0b range_error %0b",
                       code, last, err);
                errors++;
                return;
            end
            want = expected_digits.pop_front();
            if (code !== want.code) begin
                $error("digit_char: expected %0d, actual %0d", want.code, code);
                errors++;
            end
            if (last !== want.last) begin
                $error("is_last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
            if (err !== want.err) begin
                $error("range_error: expected %0b, actual %0b", want.err, err);
                errors++;
            end
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    itrd_in_if  in_ch ();
    itrd_out_if out_ch ();
    itrd_cfg_if cfg_ch ();

    integer_to_radix_digits_top #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    digit_scoreboard board;
    int              send_gap_max;
    int              recv_gap_max;
    bit              long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Digit receiver. A long hold, when requested, keeps ready low so that the
    // converter backs up into the input channel.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
            end
            gap = $urandom_range(0, recv_gap_max);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            board.check_digit(out_ch.digit_char, out_ch.is_last, out_ch.range_error);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.write_reg(idx, data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Valid stays high between back-to-back transactions.
    task automatic feed_values(input t_value vals[$]);
        int gap;
        @(negedge i_clk);
        foreach (vals[k]) begin
            gap = $urandom_range(0, send_gap_max);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.value <= vals[k];
            do @(posedge i_clk); while (!in_ch.ready);
            board.predict_digits(vals[k]);
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b0;
    endtask

    task automatic convert_batch(input t_value vals[$]);
        feed_values(vals);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly in-range values of random length; some full-width draws reach the
    // out-of-range path.
    function automatic t_value random_value();
        t_value v;
        int     pick;
        int     len;
        v = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            return v;
        end else if (pick == 2) begin
            case ($urandom_range(0, 3))
                0: v = '0;
                1: v = {1'b0, {(IN_W - 1){1'b1}}};
                2: v = {1'b1, {(IN_W - 1){1'b0}}};
                default: v = '1;
            endcase
            return v;
        end
        len = $urandom_range(1, VALUE_BITS - 1);
        return v & ((t_value'(1) << len) - t_value'(1));
    endfunction

    initial begin
        t_value            vals[$];
        logic [BASE_W-1:0] radix_list[10];
        logic [BASE_W-1:0] upper_list[10];

        board = new();
        in_ch.valid   = 1'b0;
        in_ch.value   = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_OUT_BASE;
        cfg_ch.data   = '0;
        send_gap_max  = 8;
        recv_gap_max  = 8;
        long_hold_req = 1'b0;
        i_rst_n       = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset setting, then letters in both cases and the clamped bases.
        vals = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd12345, 64'h7fff_ffff_ffff_ffff,
                 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff};
        convert_batch(vals);
        write_reg(REG_OUT_BASE, 6'd36);
        write_reg(REG_UPPER_CASE, 6'd1);
        vals = '{64'd35, 64'd36, 64'd1295, 64'h7fff_ffff_ffff_ffff};
        convert_batch(vals);
        write_reg(REG_UPPER_CASE, 6'd0);
        vals = '{64'd35, 64'd1295};
        convert_batch(vals);
        write_reg(REG_OUT_BASE, 6'd2);
        vals = '{64'h7fff_ffff_ffff_ffff, 64'd0, 64'd5};
        convert_batch(vals);
        write_reg(REG_OUT_BASE, 6'd0);
        vals = '{64'd6};
        convert_batch(vals);
        write_reg(REG_OUT_BASE, 6'd63);
        vals = '{64'd35, 64'd71};
        convert_batch(vals);

        // Random phases. Upper-case data with the low bit clear selects lower case.
        radix_list = '{6'd2, 6'd36, 6'd16, 6'd8, 6'd0, 6'd63, 6'd1, 6'd37, 6'd10, 6'd3};
        upper_list = '{6'd0, 6'd1, 6'd1, 6'd0, 6'd62, 6'd1, 6'd1, 6'd0, 6'd0, 6'd0};
        radix_list[9] = BASE_W'($urandom_range(0, 63));
        upper_list[9] = BASE_W'($urandom_range(0, 63));
        for (int ph = 0; ph < 10; ph++) begin
            if (ph % 2 == 0) begin
                write_reg(REG_OUT_BASE, radix_list[ph]);
                write_reg(REG_UPPER_CASE, upper_list[ph]);
            end else begin
                write_reg(REG_UPPER_CASE, upper_list[ph]);
                write_reg(REG_OUT_BASE, radix_list[ph]);
            end
            send_gap_max = (ph % 3 == 1) ? 0 : 8;
            recv_gap_max = (ph % 3 == 2) ? 0 : 8;
            if (ph == 3) begin
                send_gap_max  = 0;
                long_hold_req = 1'b1;
            end
            vals.delete();
            repeat (10) vals.push_back(random_value());
            convert_batch(vals);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/itrd_pkg.sv
hdl/itrd_if.sv
hdl/itrd_ram.sv
hdl/itrd_ctrl.sv
hdl/itrd_dpath.sv
hdl/integer_to_radix_digits_top.sv
bench/tb.sv
